>>> hw/rtl/prl_pkg.sv
// Shared types, codes and constants of the positional record list.
package prl_pkg;

    // Fixed field widths of a command word and a result word.
    localparam int POS_W    = 4;
    localparam int KEY_W    = 31;
    localparam int FREQ_W   = 7;
    localparam int GRADE_W  = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;

    // Default and largest list depth; TGT_W holds any count up to DEPTH_MAX.
    localparam int DEF_DEPTH = 16;
    localparam int DEPTH_MAX = 256;
    localparam int TGT_W     = $clog2(DEPTH_MAX + 1);
    localparam int DEF_CNT_W = $clog2(DEF_DEPTH + 1);

    // Command codes.
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_INNER = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REM_INNER = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_REM_KEY   = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd4;

    // Cell operation codes.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_REM  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  frequency;
        logic [GRADE_W-1:0] grade_one;
        logic [GRADE_W-1:0] grade_two;
        logic [GRADE_W-1:0] grade_three;
    } rec_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [1:0]       mode;
        logic             key_mode;
        logic [TGT_W-1:0] tgt;
        logic [TGT_W-1:0] count;
        rec_t             rec;
    } cell_cmd_t;

    // Outcome of one command.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TGT_W-1:0]    count;
    } res_t;

endpackage

>>> hw/rtl/prl_req_if.sv
// Command channel of the positional record list.
interface prl_req_if;
    import prl_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key;
    logic [FREQ_W-1:0]   frequency;
    logic [GRADE_W-1:0]  grade_one;
    logic [GRADE_W-1:0]  grade_two;
    logic [GRADE_W-1:0]  grade_three;

    modport source (
        output valid, req_type, position, key, frequency, grade_one, grade_two, grade_three,
        input  ready
    );
    modport sink (
        input  valid, req_type, position, key, frequency, grade_one, grade_two, grade_three,
        output ready
    );
endinterface

>>> hw/rtl/prl_rsp_if.sv
// Result channel of the positional record list.
interface prl_rsp_if #(
    parameter int CNT_W = prl_pkg::DEF_CNT_W
);
    import prl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [FREQ_W-1:0]   out_frequency;
    logic [GRADE_W-1:0]  out_grade_one;
    logic [GRADE_W-1:0]  out_grade_two;
    logic [GRADE_W-1:0]  out_grade_three;
    logic [CNT_W-1:0]    entry_count;

    modport source (
        output valid, status, out_key, out_frequency, out_grade_one, out_grade_two,
               out_grade_three, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_key, out_frequency, out_grade_one, out_grade_two,
               out_grade_three, entry_count,
        output ready
    );
endinterface

>>> hw/rtl/prl_cell.sv
// One list slot: holds a record and shifts toward either neighbor.
module prl_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  prl_pkg::cell_cmd_t  cmd,
    input  logic                at_in,
    input  prl_pkg::rec_t       left_rec,
    input  prl_pkg::rec_t       right_rec,
    output prl_pkg::rec_t       rec,
    output logic                at_out,
    output prl_pkg::rec_t       sel_rec
);
    import prl_pkg::*;

    localparam logic [TGT_W-1:0] IDX_V = TGT_W'(IDX);

    rec_t rec_reg;
    rec_t rec_next;
    logic occupied;
    logic match;
    logic at_here;
    logic is_target;

    // at_here is a thermometer along the chain: set from the target slot onward.
    // In key mode it starts at the first occupied slot whose key matches.
    always_comb
    begin
        occupied  = IDX_V < cmd.count;
        match     = occupied && (rec_reg.key == cmd.rec.key);
        at_here   = cmd.key_mode ? (at_in || match) : (IDX_V >= cmd.tgt);
        is_target = at_here && !at_in;
    end

    always_comb
    begin
        rec_next = rec_reg;
        unique case (cmd.mode)
            CELL_INS:
            begin
                if (is_target)
                    rec_next = cmd.rec;
                else if (at_here)
                    rec_next = left_rec;
            end
            CELL_REM:
            begin
                if (at_here)
                    rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec     = rec_reg;
    assign at_out  = at_here;
    assign sel_rec = is_target ? rec_reg : '0;

endmodule

>>> hw/rtl/prl_ctrl.sv
// Command decoder: checks each command against the count and steers the cells.
module prl_ctrl #(
    parameter int DEPTH = prl_pkg::DEF_DEPTH
) (
    input  logic [prl_pkg::REQ_W-1:0] req_type,
    input  logic [prl_pkg::POS_W-1:0] position,
    input  prl_pkg::rec_t             in_rec,
    input  logic [prl_pkg::TGT_W-1:0] count,
    input  logic                      found,
    output prl_pkg::cell_cmd_t        cmd,
    output prl_pkg::res_t             res
);
    import prl_pkg::*;

    localparam logic [TGT_W-1:0] DEPTH_V = TGT_W'(DEPTH);
    localparam logic [TGT_W-1:0] ONE     = TGT_W'(1);
    localparam logic [TGT_W-1:0] TWO     = TGT_W'(2);

    logic [TGT_W-1:0]    pos;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        pos   = TGT_W'(position);
        full  = count == DEPTH_V;
        empty = count == '0;

        cmd.mode     = CELL_HOLD;
        cmd.key_mode = 1'b0;
        cmd.tgt      = '0;
        cmd.count    = count;
        cmd.rec      = in_rec;
        status       = ST_OK;

        if ((req_type == REQ_INS_FRONT || req_type == REQ_INS_INNER ||
             req_type == REQ_INS_BACK) && full)
        begin
            status = ST_FULL;
        end
        else if (req_type inside {REQ_REM_FRONT, REQ_REM_INNER, REQ_REM_BACK, REQ_REM_KEY}
                 && empty)
        begin
            status = ST_EMPTY;
        end
        else
        begin
            unique case (req_type)
                REQ_INS_FRONT:
                begin
                    cmd.mode = CELL_INS;
                end
                REQ_INS_INNER:
                begin
                    if (empty)
                        status = ST_EMPTY;
                    else if (count < TWO || pos < ONE || pos >= count)
                        status = ST_BADPOS;
                    else
                    begin
                        cmd.mode = CELL_INS;
                        cmd.tgt  = pos;
                    end
                end
                REQ_INS_BACK:
                begin
                    if (empty)
                        status = ST_EMPTY;
                    else
                    begin
                        cmd.mode = CELL_INS;
                        cmd.tgt  = count;
                    end
                end
                REQ_REM_FRONT:
                begin
                    cmd.mode = CELL_REM;
                end
                REQ_REM_INNER:
                begin
                    if (count <= TWO || pos < ONE || (pos + ONE) >= count)
                        status = ST_BADPOS;
                    else
                    begin
                        cmd.mode = CELL_REM;
                        cmd.tgt  = pos;
                    end
                end
                REQ_REM_BACK:
                begin
                    cmd.mode = CELL_REM;
                    cmd.tgt  = count - ONE;
                end
                REQ_REM_KEY:
                begin
                    // With no match the thermometer stays clear and no cell moves.
                    cmd.mode     = CELL_REM;
                    cmd.key_mode = 1'b1;
                    status       = found ? ST_OK : ST_NOKEY;
                end
                default:
                begin
                    status = ST_BADPOS;
                end
            endcase
        end
    end

    always_comb
    begin
        res.status = status;
        res.count  = count;
        if (status == ST_OK && cmd.mode == CELL_INS)
            res.count = count + ONE;
        else if (status == ST_OK && cmd.mode == CELL_REM)
            res.count = count - ONE;
    end

endmodule

>>> hw/rtl/positional_record_list.sv
// Positional record list: a chain of record cells with a command decoder.
// A result word appears in the cycle after its command word is taken.
// Throughput: one command word per cycle while the result side is ready; a stalled
// result word holds off the next command. The chain shifts as a command is taken;
// a refused one leaves it alone. Reset clears the entry count and the result valid
// flag; record cells are not cleared, since no slot at or beyond the count is ever read.
module positional_record_list #(
    parameter int DEPTH = prl_pkg::DEF_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    prl_req_if.sink      req,
    prl_rsp_if.source    rsp
);
    import prl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;
    rec_t                out_rec_reg;
    logic [CNT_W-1:0]    out_count_reg;

    rec_t      in_rec;
    cell_cmd_t cmd;
    res_t      res;
    logic      take;
    rec_t      removed;

    rec_t recs     [DEPTH];
    rec_t sel_recs [DEPTH];
    logic at_chain [DEPTH+1];

    assign in_rec.key         = req.key;
    assign in_rec.frequency   = req.frequency;
    assign in_rec.grade_one   = req.grade_one;
    assign in_rec.grade_two   = req.grade_two;
    assign in_rec.grade_three = req.grade_three;

    assign req.ready = !valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    prl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .req_type (req.req_type),
        .position (req.position),
        .in_rec   (in_rec),
        .count    (TGT_W'(count_reg)),
        .found    (at_chain[DEPTH]),
        .cmd      (cmd),
        .res      (res)
    );

    // Cells only move on an accepted word.
    cell_cmd_t cell_cmd;
    always_comb
    begin
        cell_cmd = cmd;
        if (!take)
            cell_cmd.mode = CELL_HOLD;
    end

    assign at_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rec_t left_rec;
        rec_t right_rec;
        if (i == 0)
        begin : g_first
            assign left_rec = '0;
        end
        else
        begin : g_inner_l
            assign left_rec = recs[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_rec = '0;
        end
        else
        begin : g_inner_r
            assign right_rec = recs[i+1];
        end

        prl_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .at_in     (at_chain[i]),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .rec       (recs[i]),
            .at_out    (at_chain[i+1]),
            .sel_rec   (sel_recs[i])
        );
    end

    // At most one cell is the target, so an OR gathers the removed record.
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++)
            removed = removed | sel_recs[i];
        if (!(cmd.mode == CELL_REM && res.status == ST_OK))
            removed = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= CNT_W'(res.count);
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg    <= res.status;
            out_rec_reg   <= removed;
            out_count_reg <= CNT_W'(res.count);
        end
    end

    assign rsp.valid           = valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.out_key         = out_rec_reg.key;
    assign rsp.out_frequency   = out_rec_reg.frequency;
    assign rsp.out_grade_one   = out_rec_reg.grade_one;
    assign rsp.out_grade_two   = out_rec_reg.grade_two;
    assign rsp.out_grade_three = out_rec_reg.grade_three;
    assign rsp.entry_count     = out_count_reg;

endmodule

>>> hw/rtl/prl_checker.sv
// Port-level assertions for the positional record list, bound to the top level.
module prl_checker #(
    parameter int DEPTH = prl_pkg::DEF_DEPTH
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [prl_pkg::STATUS_W-1:0]   status,
    input logic [prl_pkg::KEY_W-1:0]      out_key,
    input logic [prl_pkg::FREQ_W-1:0]     out_frequency,
    input logic [prl_pkg::GRADE_W-1:0]    out_grade_one,
    input logic [prl_pkg::GRADE_W-1:0]    out_grade_two,
    input logic [prl_pkg::GRADE_W-1:0]    out_grade_three,
    input logic [$clog2(DEPTH+1)-1:0]     entry_count
);
    import prl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] last_reg;

    // Count carried by the last delivered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (out_valid && out_ready)
            last_reg <= entry_count;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, entry_count} <= (CNT_W+1)'(DEPTH)))
        else $error("entry count beyond list depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (out_key == '0 && out_frequency == '0 &&
            out_grade_one == '0 && out_grade_two == '0 && out_grade_three == '0))
        else $error("refused command returned a record");

    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (entry_count == last_reg))
        else $error("refused command changed the count");

    a_ok_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |->
            (({1'b0, entry_count} == ({1'b0, last_reg} + 1'b1)) ||
             ({1'b0, entry_count} + 1'b1 == {1'b0, last_reg})))
        else $error("accepted command did not move the count by one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(entry_count)))
        else $error("stalled result word changed");

endmodule

bind positional_record_list prl_checker #(
    .DEPTH (DEPTH)
) u_prl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .out_key         (rsp.out_key),
    .out_frequency   (rsp.out_frequency),
    .out_grade_one   (rsp.out_grade_one),
    .out_grade_two   (rsp.out_grade_two),
    .out_grade_three (rsp.out_grade_three),
    .entry_count     (rsp.entry_count)
);

>>> tb/tb_positional_record_list.sv
// Self-checking testbench for the positional record list with a built-in list predictor.
`timescale 1ns / 1ps

module tb_positional_record_list;
    import prl_pkg::*;

    localparam int LIST_DEPTH  = DEF_DEPTH;
    localparam int CNT_W       = DEF_CNT_W;
    localparam int N_CHUNKS    = 35;
    localparam int CHUNK_ITEMS = 50;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_STEP   = 700;
    localparam int HOLD_LAST   = 1500;
    localparam int SETTLE      = 8;

    // The command code that the block leaves unused.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  frequency;
        logic [GRADE_W-1:0] grade_one;
        logic [GRADE_W-1:0] grade_two;
        logic [GRADE_W-1:0] grade_three;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [FREQ_W-1:0]   frequency;
        logic [GRADE_W-1:0]  grade_one;
        logic [GRADE_W-1:0]  grade_two;
        logic [GRADE_W-1:0]  grade_three;
        logic [CNT_W-1:0]    entry_count;
    } outcome_t;

    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        rec_t [LIST_DEPTH-1:0]       recs;
    } list_state_t;

    logic clk;
    logic rst_n;

    prl_req_if                    req_ch ();
    prl_rsp_if #(.CNT_W(CNT_W))   rsp_ch ();

    positional_record_list #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    command_t    pending_cmds[$];
    outcome_t    outcomes_due[$];
    list_state_t live_list;
    list_state_t plan_list;
    int          n_queued;
    int          n_taken;
    int          errors;
    int          quiet_cycles;
    int          src_gap;
    int          sink_gap;
    int          hold_left;
    int          next_hold_at;
    bit          cmd_taken;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          growing;

    function automatic void insert_record(inout list_state_t s, input int at,
                                          input command_t c);
        for (int i = s.cnt; i > at; i--)
            s.recs[i] = s.recs[i - 1];
        s.recs[at].key         = c.key;
        s.recs[at].frequency   = c.frequency;
        s.recs[at].grade_one   = c.grade_one;
        s.recs[at].grade_two   = c.grade_two;
        s.recs[at].grade_three = c.grade_three;
        s.cnt = s.cnt + 1'b1;
    endfunction

    function automatic void take_record(inout list_state_t s, input int at,
                                        inout outcome_t r);
        r.key         = s.recs[at].key;
        r.frequency   = s.recs[at].frequency;
        r.grade_one   = s.recs[at].grade_one;
        r.grade_two   = s.recs[at].grade_two;
        r.grade_three = s.recs[at].grade_three;
        for (int i = at; i + 1 < s.cnt; i++)
            s.recs[i] = s.recs[i + 1];
        s.cnt = s.cnt - 1'b1;
    endfunction

    // Applies one command word to a list and returns the result word it gives.
    function automatic outcome_t apply_command(inout list_state_t s, input command_t c);
        outcome_t r;
        int       n;
        int       p;
        int       hit;
        r        = '0;
        r.status = ST_OK;
        n        = s.cnt;
        p        = c.position;
        hit      = -1;
        if (c.req_type <= REQ_INS_BACK && n >= LIST_DEPTH)
            r.status = ST_FULL;
        else if (c.req_type == REQ_UNUSED)
            r.status = ST_BADPOS;
        else if (c.req_type >= REQ_REM_FRONT && n == 0)
            r.status = ST_EMPTY;
        else
        begin
            case (c.req_type)
                REQ_INS_FRONT:
                    insert_record(s, 0, c);
                REQ_INS_INNER:
                    if (n == 0)
                        r.status = ST_EMPTY;
                    else if (n < 2 || p < 1 || p >= n)
                        r.status = ST_BADPOS;
                    else
                        insert_record(s, p, c);
                REQ_INS_BACK:
                    if (n == 0)
                        r.status = ST_EMPTY;
                    else
                        insert_record(s, n, c);
                REQ_REM_FRONT:
                    hit = 0;
                REQ_REM_INNER:
                    if (n <= 2 || p < 1 || p + 1 >= n)
                        r.status = ST_BADPOS;
                    else
                        hit = p;
                REQ_REM_BACK:
                    hit = n - 1;
                default:
                begin
                    // Remove by key takes the first matching record from the front.
                    r.status = ST_NOKEY;
                    for (int i = n - 1; i >= 0; i--)
                        if (s.recs[i].key == c.key)
                            hit = i;
                end
            endcase
        end
        if (hit >= 0)
        begin
            r.status = ST_OK;
            take_record(s, hit, r);
        end
        r.entry_count = s.cnt;
        return r;
    endfunction

    function automatic command_t make_cmd(logic [REQ_W-1:0] rt, int pos, logic [KEY_W-1:0] k,
                                          int freq, logic [GRADE_W-1:0] g1,
                                          logic [GRADE_W-1:0] g2, logic [GRADE_W-1:0] g3);
        command_t c;
        c.req_type    = rt;
        c.position    = POS_W'(pos);
        c.key         = k;
        c.frequency   = FREQ_W'(freq);
        c.grade_one   = g1;
        c.grade_two   = g2;
        c.grade_three = g3;
        return c;
    endfunction

    task automatic queue_cmd(input command_t c);
        outcome_t unused;
        pending_cmds.push_back(c);
        unused   = apply_command(plan_list, c);
        n_queued = n_queued + 1;
    endtask

    // Mostly commands that make sense for the planned list, so that it keeps
    // swinging between empty and full; the rest is arbitrary.
    task automatic gen_random_item();
        command_t c;
        int       n;
        int       pick;
        n             = plan_list.cnt;
        c.key         = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
        c.frequency   = FREQ_W'($urandom_range(0, 100));
        c.grade_one   = $urandom;
        c.grade_two   = $urandom;
        c.grade_three = $urandom;
        c.position    = POS_W'($urandom);
        if (n == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
        else if (n == LIST_DEPTH && $urandom_range(0, 2) == 0)
            growing = 1'b0;
        else if ($urandom_range(0, 39) == 0)
            growing = !growing;
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 12)
            c.req_type = REQ_W'($urandom_range(0, 7));
        else if (growing)
        begin
            if (n == 0 || pick == 0)
                c.req_type = REQ_INS_FRONT;
            else if (pick == 1 && n >= 2)
            begin
                c.req_type = REQ_INS_INNER;
                c.position = POS_W'($urandom_range(1, n - 1));
            end
            else
                c.req_type = REQ_INS_BACK;
        end
        else
        begin
            case (pick)
                0: c.req_type = REQ_REM_FRONT;
                1:
                    if (n > 2)
                    begin
                        c.req_type = REQ_REM_INNER;
                        c.position = POS_W'($urandom_range(1, n - 2));
                    end
                    else
                        c.req_type = REQ_REM_BACK;
                2: c.req_type = REQ_REM_BACK;
                default:
                begin
                    c.req_type = REQ_REM_KEY;
                    if (n > 0 && $urandom_range(0, 3) != 0)
                        c.key = plan_list.recs[$urandom_range(0, n - 1)].key;
                end
            endcase
        end
        queue_cmd(c);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] seen_v);
        if (want_v !== seen_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, seen_v);
            errors = errors + 1;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Command driver: a word stays on the channel until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || cmd_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (src_idle_on && $urandom_range(0, 7) == 0)
            begin
                src_gap = $urandom_range(0, 4);
                req_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                command_t c;
                c = pending_cmds.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= c.req_type;
                req_ch.position    <= c.position;
                req_ch.key         <= c.key;
                req_ch.frequency   <= c.frequency;
                req_ch.grade_one   <= c.grade_one;
                req_ch.grade_two   <= c.grade_two;
                req_ch.grade_three <= c.grade_three;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result receiver, with an occasional long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (n_taken >= next_hold_at && next_hold_at <= HOLD_LAST)
        begin
            hold_left    = HOLD_CYCLES - 1;
            next_hold_at = next_hold_at + HOLD_STEP;
            rsp_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Result checker and command tracker.
    always @(posedge clk)
    begin : watch_channels
        outcome_t seen;
        outcome_t want;
        command_t c;
        bit       moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved            = 1'b1;
                seen.status      = rsp_ch.status;
                seen.key         = rsp_ch.out_key;
                seen.frequency   = rsp_ch.out_frequency;
                seen.grade_one   = rsp_ch.out_grade_one;
                seen.grade_two   = rsp_ch.out_grade_two;
                seen.grade_three = rsp_ch.out_grade_three;
                seen.entry_count = rsp_ch.entry_count;
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, status %h count %h",
                             $time, seen.status, seen.entry_count);
                    errors = errors + 1;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("out_key", 32'(want.key), 32'(seen.key));
                    check_field("out_frequency", 32'(want.frequency), 32'(seen.frequency));
                    check_field("out_grade_one", want.grade_one, seen.grade_one);
                    check_field("out_grade_two", want.grade_two, seen.grade_two);
                    check_field("out_grade_three", want.grade_three, seen.grade_three);
                    check_field("entry_count", 32'(want.entry_count), 32'(seen.entry_count));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved         = 1'b1;
                c.req_type    = req_ch.req_type;
                c.position    = req_ch.position;
                c.key         = req_ch.key;
                c.frequency   = req_ch.frequency;
                c.grade_one   = req_ch.grade_one;
                c.grade_two   = req_ch.grade_two;
                c.grade_three = req_ch.grade_three;
                outcomes_due.push_back(apply_command(live_list, c));
                n_taken <= n_taken + 1;
            end
            cmd_taken <= req_ch.valid && req_ch.ready;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_INS_FRONT;
        req_ch.position    = '0;
        req_ch.key         = '0;
        req_ch.frequency   = '0;
        req_ch.grade_one   = '0;
        req_ch.grade_two   = '0;
        req_ch.grade_three = '0;
        rsp_ch.ready       = 1'b0;
        live_list          = '0;
        plan_list          = '0;
        n_queued           = 0;
        n_taken            = 0;
        errors             = 0;
        quiet_cycles       = 0;
        src_gap            = 0;
        sink_gap           = 0;
        hold_left          = 0;
        next_hold_at       = 300;
        cmd_taken          = 1'b0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        growing            = 1'b1;

        // Every command on an empty list, then the refusals around small counts.
        queue_cmd(make_cmd(REQ_REM_FRONT, 0, 31'd3, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_INNER, 1, 31'd3, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_BACK, 0, 31'd3, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_KEY, 0, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_INS_INNER, 1, 31'd4, 10, 32'd1, 32'd2, 32'd3));
        queue_cmd(make_cmd(REQ_INS_BACK, 0, 31'd4, 10, 32'd1, 32'd2, 32'd3));
        queue_cmd(make_cmd(REQ_UNUSED, 15, 31'd4, 10, 32'd1, 32'd2, 32'd3));
        queue_cmd(make_cmd(REQ_INS_FRONT, 15, 31'h7fff_ffff, 100,
                           32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        queue_cmd(make_cmd(REQ_INS_INNER, 0, 31'd6, 1, 32'd6, 32'd6, 32'd6));
        queue_cmd(make_cmd(REQ_INS_BACK, 0, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_INS_INNER, 0, 31'd6, 1, 32'd6, 32'd6, 32'd6));
        queue_cmd(make_cmd(REQ_INS_INNER, 2, 31'd6, 1, 32'd6, 32'd6, 32'd6));
        queue_cmd(make_cmd(REQ_INS_INNER, 1, 31'd5, 63,
                           32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_0000));
        queue_cmd(make_cmd(REQ_REM_INNER, 0, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_INNER, 2, 31'd0, 0, '0, '0, '0));
        // A duplicate key at the front: remove by key must take the front one.
        queue_cmd(make_cmd(REQ_INS_FRONT, 0, 31'd5, 1, 32'd11, 32'd12, 32'd13));
        queue_cmd(make_cmd(REQ_REM_KEY, 0, 31'd5, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_KEY, 0, 31'd12345, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_INNER, 1, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_INNER, 1, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_KEY, 0, 31'h7fff_ffff, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_REM_BACK, 0, 31'd0, 0, '0, '0, '0));
        // Emptying the list from the front, then building it up again at both ends.
        queue_cmd(make_cmd(REQ_INS_FRONT, 15, 31'd9, 99, 32'd9, 32'd9, 32'd9));
        queue_cmd(make_cmd(REQ_REM_FRONT, 0, 31'd0, 0, '0, '0, '0));
        queue_cmd(make_cmd(REQ_INS_FRONT, 0, 31'd1, 50, 32'd1, 32'd1, 32'd1));
        queue_cmd(make_cmd(REQ_INS_BACK, 0, 31'd2, 51, 32'd2, 32'd2, 32'd2));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int chunk = 0; chunk < N_CHUNKS; chunk++)
        begin
            while (pending_cmds.size() >= 4)
                @(posedge clk);
            src_idle_on  = (chunk < N_CHUNKS - 3) && (chunk % 5 != 2);
            sink_idle_on = (chunk < N_CHUNKS - 3) && (chunk % 5 != 4);
            repeat (CHUNK_ITEMS) gen_random_item();
        end

        while (n_taken != n_queued || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (errors == 0 && outcomes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> positional_record_list.f
hw/rtl/prl_pkg.sv
hw/rtl/prl_req_if.sv
hw/rtl/prl_rsp_if.sv
hw/rtl/prl_cell.sv
hw/rtl/prl_ctrl.sv
hw/rtl/positional_record_list.sv
hw/rtl/prl_checker.sv
tb/tb_positional_record_list.sv
